FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules.
// No dependencies; expects signals named clk and arst_n in the user's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is applied.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/mcfir_pkg.sv
// Shared constants, types and the coefficient function for the multichannel FIR.
// No dependencies.
package mcfir_pkg;

	localparam int TAPS            = 64;
	localparam int CHANNELS        = 4;
	localparam int COEF_FRAC_BITS  = 17;
	localparam int TABLE_FRAC_BITS = 17;

	localparam int IDX_W  = $clog2(TAPS);
	localparam int FILL_W = $clog2(TAPS + 1);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ADDR_W = $clog2(CHANNELS * TAPS);
	localparam int SMP_W  = 16;
	localparam int CHN_W  = 2;
	localparam int OUT_W  = 18;
	// Largest Q0.17 tap magnitude is below 2^14, so 15 signed bits at 17 fraction bits.
	localparam int COEF_W = COEF_FRAC_BITS - 2;
	localparam int PROD_W = SMP_W + 1 + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(TAPS) + 1;

	localparam int UP_SH = (COEF_FRAC_BITS >= TABLE_FRAC_BITS) ?
		COEF_FRAC_BITS - TABLE_FRAC_BITS : 0;
	localparam int DN_SH = (COEF_FRAC_BITS < TABLE_FRAC_BITS) ?
		TABLE_FRAC_BITS - COEF_FRAC_BITS : 0;

	localparam int COEF_Q17 [64] = '{
		  131,    65,    64,    44,     1,   -70,  -172,  -306,
		 -468,  -652,  -847, -1039, -1207, -1330, -1385, -1348,
		-1196,  -912,  -481,   101,   833,  1703,  2689,  3763,
		 4885,  6014,  7100,  8098,  8960,  9647, 10124, 10369,
		10369, 10124,  9647,  8960,  8098,  7100,  6014,  4885,
		 3763,  2689,  1703,   833,   101,  -481,  -912, -1196,
		-1348, -1385, -1330, -1207, -1039,  -847,  -652,  -468,
		 -306,  -172,   -70,     1,    44,    64,    65,   131
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND
	} state_t;

	typedef struct packed {
		logic             load;
		logic             write;
		logic             acc_clr;
		logic             issue;
		logic [IDX_W-1:0] tap;
		logic             out_load;
	} fir_cmd_t;

	typedef struct packed {
		logic ch_ok;
		logic out_free;
	} fir_sts_t;

	// Tap k at COEF_FRAC_BITS fraction bits; narrowing rounds half away from zero.
	function automatic logic signed [COEF_W-1:0] coef_at(input logic [IDX_W-1:0] k);
		int c;
		int mag;
		int r;
		c   = COEF_Q17[k];
		mag = (c < 0) ? -c : c;
		r   = ((mag + ((1 << DN_SH) >> 1)) >> DN_SH) << UP_SH;
		return COEF_W'((c < 0) ? -r : r);
	endfunction

endpackage

FILE: hw/rtl/mcfir_ctrl.sv
// Sequencer for the multichannel FIR: accept, write, tap sweep, drain, output.
// Depends on mcfir_pkg.
module mcfir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  mcfir_pkg::fir_sts_t  sts,
	output mcfir_pkg::fir_cmd_t  cmd
);

	mcfir_pkg::state_t                state_q, state_d;
	logic [mcfir_pkg::IDX_W-1:0]      tap_q, tap_d;
	logic                             drain_q, drain_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcfir_pkg::ST_IDLE;
			tap_q   <= '0;
			drain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
			drain_q <= drain_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		tap_d    = tap_q;
		drain_d  = drain_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.tap  = tap_q;
		unique case (state_q)
			mcfir_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					// unbuilt channel: item is taken and dropped
					if (sts.ch_ok) state_d = mcfir_pkg::ST_WRITE;
				end
			end
			mcfir_pkg::ST_WRITE: begin
				cmd.write   = 1'b1;
				cmd.acc_clr = 1'b1;
				tap_d       = '0;
				state_d     = mcfir_pkg::ST_MAC;
			end
			mcfir_pkg::ST_MAC: begin
				cmd.issue = 1'b1;
				tap_d     = tap_q + 1'b1;
				if (tap_q == mcfir_pkg::IDX_W'(mcfir_pkg::TAPS - 1)) begin
					drain_d = 1'b0;
					state_d = mcfir_pkg::ST_DRAIN;
				end
			end
			mcfir_pkg::ST_DRAIN: begin
				// read/coef stage and product stage empty out
				drain_d = 1'b1;
				if (drain_q) state_d = mcfir_pkg::ST_ROUND;
			end
			mcfir_pkg::ST_ROUND: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mcfir_pkg::ST_IDLE;
				end
			end
			default: state_d = mcfir_pkg::ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/mcfir_dp.sv
// Datapath for the multichannel FIR: history memory, pointers, MAC pipeline,
// rounding and the output register. Depends on mcfir_pkg.
module mcfir_dp (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  mcfir_pkg::fir_cmd_t                     cmd,
	output mcfir_pkg::fir_sts_t                     sts,
	input  logic [mcfir_pkg::CHN_W-1:0]             channel,
	input  logic [mcfir_pkg::SMP_W-1:0]             sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic [mcfir_pkg::CHN_W-1:0]             out_channel,
	output logic signed [mcfir_pkg::OUT_W-1:0]      filtered
);

	localparam int CF = mcfir_pkg::COEF_FRAC_BITS;
	localparam logic [mcfir_pkg::ACC_W:0] RND_BIAS = (mcfir_pkg::ACC_W + 1)'((1 << CF) - 1);

	logic [mcfir_pkg::SMP_W-1:0]  hist_mem [mcfir_pkg::CHANNELS * mcfir_pkg::TAPS];
	logic [mcfir_pkg::IDX_W-1:0]  wptr_q [mcfir_pkg::CHANNELS];
	logic [mcfir_pkg::FILL_W-1:0] fill_q [mcfir_pkg::CHANNELS];

	logic [mcfir_pkg::CHN_W-1:0]  ch_q;
	logic [mcfir_pkg::SMP_W-1:0]  smp_q;
	logic [mcfir_pkg::IDX_W-1:0]  newest_q;
	logic [mcfir_pkg::FILL_W-1:0] fill_sel_q;
	logic [mcfir_pkg::CH_W-1:0]   ch_sel;
	logic [mcfir_pkg::IDX_W-1:0]  cur_ptr;
	logic [mcfir_pkg::FILL_W-1:0] cur_fill;

	logic [mcfir_pkg::IDX_W:0]    idx_wide;
	logic [mcfir_pkg::IDX_W-1:0]  rd_idx;
	logic [mcfir_pkg::ADDR_W-1:0] wr_addr, rd_addr;

	logic [mcfir_pkg::SMP_W-1:0]         smp_s1;
	logic                                vld_s1, issue_s1;
	logic signed [mcfir_pkg::COEF_W-1:0] coef_s1;
	logic signed [mcfir_pkg::PROD_W-1:0] prod_s2;
	logic                                issue_s2;
	logic signed [mcfir_pkg::ACC_W-1:0]  acc_q;
	logic signed [mcfir_pkg::ACC_W:0]    rnd;

	logic                                out_valid_q;
	logic [mcfir_pkg::CHN_W-1:0]         out_channel_q;
	logic signed [mcfir_pkg::OUT_W-1:0]  filtered_q;

	assign sts.ch_ok    = int'(channel) < mcfir_pkg::CHANNELS;
	assign sts.out_free = !out_valid_q || out_ready;

	assign ch_sel   = mcfir_pkg::CH_W'(ch_q);
	assign cur_ptr  = wptr_q[ch_sel];
	assign cur_fill = fill_q[ch_sel];

	// tap i reads the slot i steps behind the newest sample, wrapping
	assign idx_wide = (newest_q >= cmd.tap) ?
		(mcfir_pkg::IDX_W + 1)'(newest_q - cmd.tap) :
		(mcfir_pkg::IDX_W + 1)'(int'(newest_q) + mcfir_pkg::TAPS - int'(cmd.tap));
	assign rd_idx  = idx_wide[mcfir_pkg::IDX_W-1:0];
	assign wr_addr = mcfir_pkg::ADDR_W'(int'(ch_sel) * mcfir_pkg::TAPS + int'(cur_ptr));
	assign rd_addr = mcfir_pkg::ADDR_W'(int'(ch_sel) * mcfir_pkg::TAPS + int'(rd_idx));

	// history memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write) hist_mem[wr_addr] <= smp_q;
		if (cmd.issue) smp_s1 <= hist_mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= channel;
			smp_q <= sample;
		end
		if (cmd.write) begin
			newest_q   <= cur_ptr;
			fill_sel_q <= (int'(cur_fill) < mcfir_pkg::TAPS) ? cur_fill + 1'b1 : cur_fill;
		end
		if (cmd.issue) begin
			// slots never written read as zero (fill count per channel)
			vld_s1  <= int'(rd_idx) < int'(fill_sel_q);
			coef_s1 <= mcfir_pkg::coef_at(cmd.tap);
		end
		prod_s2 <= $signed({1'b0, (vld_s1 ? smp_s1 : '0)}) * coef_s1;
		if (cmd.out_load) begin
			out_channel_q <= ch_q;
			filtered_q    <= rnd[CF + mcfir_pkg::OUT_W - 1:CF];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < mcfir_pkg::CHANNELS; c++) begin
				wptr_q[c] <= '0;
				fill_q[c] <= '0;
			end
		end else if (cmd.write) begin
			wptr_q[ch_sel] <= (int'(cur_ptr) == mcfir_pkg::TAPS - 1) ? '0 : cur_ptr + 1'b1;
			if (int'(cur_fill) < mcfir_pkg::TAPS) fill_q[ch_sel] <= cur_fill + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1    <= 1'b0;
			issue_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
		end else begin
			issue_s1 <= cmd.issue;
			issue_s2 <= issue_s1;
			if (cmd.acc_clr) acc_q <= '0;
			else if (issue_s2) acc_q <= acc_q + mcfir_pkg::ACC_W'(prod_s2);
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// truncate toward zero: bias negative sums by 2^CF-1 before the shift
	assign rnd = {acc_q[mcfir_pkg::ACC_W-1], acc_q} +
		(acc_q[mcfir_pkg::ACC_W-1] ? RND_BIAS : '0);

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign filtered    = filtered_q;

endmodule

FILE: hw/rtl/multichannel_fir_lowpass_unit.sv
// From input accept to result valid an item passes the write, MAC, drain and round states.
// One item at a time: the single shared multiply-accumulate walks all 64 taps.
// Input ready only while idle; a finished result waits in the output register meanwhile.
// An item for a channel that is not built is taken and gives no result.
// Reset (arst_n low, async): sequencer idle, output empty, all write pointers and fill
// counts zero, so every history reads as zeros; the memory itself is not cleared.
module multichannel_fir_lowpass_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [mcfir_pkg::CHN_W-1:0]         channel,
	input  logic [mcfir_pkg::SMP_W-1:0]         sample,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [mcfir_pkg::CHN_W-1:0]         out_channel,
	output logic signed [mcfir_pkg::OUT_W-1:0]  filtered
);

	// command/status link between sequencer and datapath
	mcfir_pkg::fir_cmd_t cmd;
	mcfir_pkg::fir_sts_t sts;

	// sequencer: idle -> write sample -> 64 tap reads -> drain -> load output
	mcfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: per-channel circular history in one memory, one MAC pipeline
	// (read + coefficient, product, accumulate), round-toward-zero, output reg
	mcfir_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.filtered    (filtered)
	);

endmodule

FILE: hw/rtl/mcfir_chk.sv
// Port-level checks for the multichannel FIR top level, attached by bind.
// Depends on mcfir_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcfir_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [mcfir_pkg::CHN_W-1:0]         channel,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [mcfir_pkg::CHN_W-1:0]         out_channel,
	input logic signed [mcfir_pkg::OUT_W-1:0]  filtered
);

	logic take_built;

	assign take_built = in_valid && in_ready && (int'(channel) < mcfir_pkg::CHANNELS);

	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_channel) && $stable(filtered), "result changed while stalled")
	`ASSERT_CLK(a_busy_after_take, take_built |=> !in_ready, "input taken again while filtering")
	`ASSERT_CLK(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result appeared without a filter pass")
	`ASSERT_NEVER(a_range, out_valid && filtered[17] && !(filtered[16] && filtered[15]), "filtered value below range")

endmodule

bind multichannel_fir_lowpass_unit mcfir_chk u_mcfir_chk (.*);

FILE: dv/multichannel_fir_lowpass_unit_checker.sv
// Checker for the multichannel FIR low-pass unit: recomputes each filtered value.
// Depends on mcfir_pkg for port widths, tap count, channel count and fraction bits.
module multichannel_fir_lowpass_unit_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [mcfir_pkg::CHN_W-1:0]         channel,
	input  logic [mcfir_pkg::SMP_W-1:0]         sample,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [mcfir_pkg::CHN_W-1:0]         out_channel,
	input  logic signed [mcfir_pkg::OUT_W-1:0]  filtered,
	output int                                  errors,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import mcfir_pkg::*;

	// Published low-pass taps in Q0.17.
	localparam int LOWPASS_FRAC = 17;
	localparam int LOWPASS_Q17 [64] = '{
		  131,    65,    64,    44,     1,   -70,  -172,  -306,
		 -468,  -652,  -847, -1039, -1207, -1330, -1385, -1348,
		-1196,  -912,  -481,   101,   833,  1703,  2689,  3763,
		 4885,  6014,  7100,  8098,  8960,  9647, 10124, 10369,
		10369, 10124,  9647,  8960,  8098,  7100,  6014,  4885,
		 3763,  2689,  1703,   833,   101,  -481,  -912, -1196,
		-1348, -1385, -1330, -1207, -1039,  -847,  -652,  -468,
		 -306,  -172,   -70,     1,    44,    64,    65,   131
	};

	logic [SMP_W-1:0]        history [CHANNELS][TAPS];
	int unsigned             next_slot [CHANNELS];
	logic [CHN_W-1:0]        pending_channel [$];
	logic signed [OUT_W-1:0] pending_filtered [$];
	int                      fails = 0;

	// Store the sample, then sum tap i against the sample i steps back.
	function automatic logic signed [OUT_W-1:0] filter_step(input int unsigned ch,
			input logic [SMP_W-1:0] smp);
		longint      acc;
		longint      w;
		longint      mag;
		int          sh;
		int unsigned newest;
		int unsigned idx;
		acc    = 0;
		newest = next_slot[ch];
		history[ch][newest] = smp;
		next_slot[ch] = (newest + 1 >= TAPS) ? 0 : newest + 1;
		for (int i = 0; i < TAPS; i++) begin
			idx = (newest + TAPS - i) % TAPS;
			w   = LOWPASS_Q17[i];
			if (COEF_FRAC_BITS >= LOWPASS_FRAC) begin
				sh = COEF_FRAC_BITS - LOWPASS_FRAC;
				w  = w * (longint'(1) << sh);
			end else begin
				sh  = LOWPASS_FRAC - COEF_FRAC_BITS;
				mag = (w < 0) ? -w : w;
				mag = (mag + ((longint'(1) << sh) >>> 1)) >>> sh;
				w   = (w < 0) ? -mag : mag;
			end
			acc += longint'({48'd0, history[ch][idx]}) * w;
		end
		// truncate toward zero
		if (acc < 0)
			acc = -((-acc) >>> COEF_FRAC_BITS);
		else
			acc = acc >>> COEF_FRAC_BITS;
		return acc[OUT_W-1:0];
	endfunction

	always @(posedge clk) begin
		logic [CHN_W-1:0]        want_ch;
		logic signed [OUT_W-1:0] want_val;
		if (!arst_n) begin
			foreach (history[c, t])
				history[c][t] = '0;
			foreach (next_slot[c])
				next_slot[c] = 0;
			pending_channel.delete();
			pending_filtered.delete();
		end else begin
			if (in_valid && in_ready && channel < CHANNELS) begin
				pending_channel.push_back(channel);
				pending_filtered.push_back(filter_step(channel, sample));
			end
			if (out_valid && out_ready) begin
				if (pending_channel.size() == 0) begin
					fails++;
					$display("%0t: unexpected result: expected none, actual channel %0d filtered %0d",
						$time, out_channel, filtered);
				end else begin
					want_ch  = pending_channel.pop_front();
					want_val = pending_filtered.pop_front();
					if (out_channel !== want_ch) begin
						fails++;
						$display("%0t: out_channel mismatch: expected %0d actual %0d",
							$time, want_ch, out_channel);
					end
					if (filtered !== want_val) begin
						fails++;
						$display("%0t: filtered mismatch on channel %0d: expected %0d actual %0d",
							$time, want_ch, want_val, filtered);
					end
				end
			end
		end
		errors  <= fails;
		pending <= pending_channel.size();
	end

endmodule

FILE: dv/multichannel_fir_lowpass_unit_tb.sv
// Testbench top for the multichannel FIR low-pass unit: drives items, paces the result side.
// Depends on mcfir_pkg, multichannel_fir_lowpass_unit and multichannel_fir_lowpass_unit_checker.
module multichannel_fir_lowpass_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mcfir_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	// Watchdog limit in cycles for a run of 1220 to 1299 items.
	localparam int LIMIT_CYCLES = 1_000_000;
	// Extra wait once nothing is pending.
	localparam int DRAIN_CYCLES = 100;
	// Result-side hold-off long enough to back the block up into its input.
	localparam int HOLD_OFF_CYCLES = 800;
	localparam int HOLD_OFF_AFTER  = 300;

	// Directed items: extremes, every channel, alternating bit patterns.
	localparam int DIR_ITEMS = 20;
	localparam logic [CHN_W-1:0] DIR_CH [DIR_ITEMS] = '{
		2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2,
		2'd2, 2'd2, 2'd3, 2'd3, 2'd3, 2'd3, 2'd0, 2'd1, 2'd2, 2'd3
	};
	localparam logic [SMP_W-1:0] DIR_SMP [DIR_ITEMS] = '{
		16'hFFFF, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'hFFFF, 16'hFFFF,
		16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'hFFFF, 16'hFFFF,
		16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF
	};

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [CHN_W-1:0]        channel   = '0;
	logic [SMP_W-1:0]        sample    = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CHN_W-1:0]        out_channel;
	logic signed [OUT_W-1:0] filtered;

	int errors;
	int pending;
	int accepted  = 0;
	int cycles    = 0;
	bit held_off  = 1'b0;

	always #10 clk = ~clk;

	multichannel_fir_lowpass_unit uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.filtered    (filtered)
	);

	multichannel_fir_lowpass_unit_checker fir_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.channel     (channel),
		.sample      (sample),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_channel (out_channel),
		.filtered    (filtered),
		.errors      (errors),
		.pending     (pending)
	);

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("multichannel_fir_lowpass_unit_tb NOT OK");
			$finish;
		end
	end

	// Offer one item and hold it until the edge that takes it.
	// in_ready read right after the edge is still its pre-edge value.
	task automatic offer_sample(input logic [CHN_W-1:0] ch, input logic [SMP_W-1:0] smp);
		in_valid <= 1'b1;
		channel  <= ch;
		sample   <= smp;
		do
			@(posedge clk);
		while (!in_ready);
		accepted++;
	endtask

	// Result side: random stall patterns, plus one long hold-off once traffic is going.
	initial begin
		int mode;
		int len;
		wait (arst_n);
		forever begin
			if (!held_off && accepted >= HOLD_OFF_AFTER) begin
				// sender keeps offering; the block fills its output register and stops
				// taking items until this ends
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				held_off = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(20, 400);
				for (int k = 0; k < len; k++) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= ($urandom_range(0, 7) != 0);
						default: out_ready <= ((k % 16) < 5);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		int               sent;
		int               burst;
		int               shape;
		int               gap;
		int               period;
		int               phase;
		logic [CHN_W-1:0] ch;
		logic [SMP_W-1:0] level;
		logic [SMP_W-1:0] smp;
		sent  = 0;
		phase = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, back to back.
		for (int i = 0; i < DIR_ITEMS; i++)
			offer_sample(DIR_CH[i], DIR_SMP[i]);
		in_valid <= 1'b0;
		repeat (3) @(posedge clk);

		// Random part: bursts of one shaped sequence on one channel, or noise.
		// Runs longer than the tap count fill a history with max or a square wave
		// so both ends of the output range get reached.
		while (sent < RANDOM_ITEMS) begin
			burst  = $urandom_range(1, 80);
			shape  = $urandom_range(0, 5);
			ch     = CHN_W'($urandom_range(0, 3));
			period = $urandom_range(2, 48);
			level  = SMP_W'($urandom);
			for (int k = 0; k < burst; k++) begin
				case (shape)
					0: begin
						ch  = CHN_W'($urandom_range(0, 3));
						smp = SMP_W'($urandom);
					end
					1: smp = 16'hFFFF;
					2: smp = 16'h0000;
					3: smp = ((phase / period) % 2) ? 16'hFFFF : 16'h0000;
					4: smp = SMP_W'(1) << $urandom_range(0, SMP_W - 1);
					default: smp = level;
				endcase
				phase++;
				offer_sample(ch, smp);
				sent++;
			end
			// a quarter of the bursts run straight into the next one
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		// Let the checker see the last accept before trusting its pending count.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && pending == 0)
			$display("multichannel_fir_lowpass_unit_tb OK");
		else
			$display("multichannel_fir_lowpass_unit_tb NOT OK");
		$finish;
	end

endmodule
